/* rtl/core/lsr_pkg.sv */
// Shared constants and the command record passed from front to back.
`timescale 1ns / 1ps

package lsr_pkg;

  // Widest supported coordinate and color; the command record is sized for these.
  localparam int COORD_MAX_BITS = 15;
  localparam int COLOR_MAX_BITS = 32;
  localparam int ERR_BITS       = COORD_MAX_BITS + 2;
  localparam int SPAN_LEN_BITS  = 16;

  // Request opcodes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // Pending span kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_HORIZ = 2'd2;
  localparam logic [1:0] KIND_VERT  = 2'd3;

  // Decoded request. kind/fixed/low/high describe a flat line; the rest a sloped one.
  typedef struct packed {
    logic                             op;
    logic [1:0]                       kind;
    logic signed [COORD_MAX_BITS-1:0] fixed;
    logic signed [COORD_MAX_BITS-1:0] low;
    logic signed [COORD_MAX_BITS-1:0] high;
    logic signed [COORD_MAX_BITS-1:0] x0;
    logic signed [COORD_MAX_BITS-1:0] y0;
    logic signed [COORD_MAX_BITS-1:0] x1;
    logic signed [COORD_MAX_BITS-1:0] y1;
    logic [COORD_MAX_BITS-1:0]        abs_dx;
    logic [COORD_MAX_BITS-1:0]        abs_dy;
    logic                             step_x_neg;
    logic                             step_y_neg;
    logic signed [ERR_BITS-1:0]       err0;
    logic [COLOR_MAX_BITS-1:0]        color;
  } lsr_cmd_t;

endpackage

/* rtl/core/lsr_if.sv */
// Request and span channel interfaces.
`timescale 1ns / 1ps

interface lsr_req_if #(
  parameter int COORD_BITS = 15,
  parameter int COLOR_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0]        line_color;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, cmd, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

interface lsr_span_if #(
  parameter int COORD_BITS = 15,
  parameter int COLOR_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] span_x;
  logic signed [COORD_BITS-1:0] span_y;
  logic [15:0]                  span_width;
  logic [15:0]                  span_height;
  logic [COLOR_BITS-1:0]        span_color;
  logic                         last_span;

  modport source (output valid, span_x, span_y, span_width, span_height, span_color,
                  last_span, input ready);
  modport sink (input valid, span_x, span_y, span_width, span_height, span_color,
                last_span, output ready);
endinterface

/* rtl/core/line_span_rasterizer.sv */
// Top level of the line span rasterizer: request intake, command queue, walker.
//
// Usage: the req channel takes items with cmd = load (two endpoints and a
// color, no result) or cmd = next (ask for the next span of the loaded line).
// The span channel returns one rectangle per span: x/y of the top-left,
// width and height (one of them 1), the color and a last_span flag.
// A next item with no line loaded, or after the last span, gives no result.
// An item passes through the command queue; a flat line gives its span
// from the walker's final state. A sloped line walks one pixel per cycle
// in the walker while its output register can take a span, so a next item
// gathers pixels through the single Bresenham step unit until a span
// closes; the closing span of a line comes from the final state.
// Stalls: the walker holds in place while its output register is full and
// not taken; the command queue (QUEUE_DEPTH items) keeps accepting until
// full, then req.ready drops.
// Reset (rst, synchronous): empties the queue, drops any loaded line and
// clears the output valid.
`timescale 1ns / 1ps

module line_span_rasterizer import lsr_pkg::*; #(
  parameter int COORD_BITS  = 15,
  parameter int COLOR_BITS  = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  lsr_req_if.sink    req,
  lsr_span_if.source span
);

  logic     q_full;
  logic     q_push;
  lsr_cmd_t q_push_cmd;
  logic     q_pop;
  logic     q_valid;
  lsr_cmd_t q_cmd;

  // front: handshake and request decode
  lsr_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .req  (req),
    .full (q_full),
    .push (q_push),
    .cmd  (q_push_cmd)
  );

  // decoupling queue so intake and walker stall independently
  lsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // back: pixel walk, span merge, registered output
  lsr_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .span    (span)
  );

endmodule

/* rtl/core/lsr_front.sv */
// Request intake: accepts items and decodes them into command records.
`timescale 1ns / 1ps

module lsr_front import lsr_pkg::*; #(
  parameter int COORD_BITS = 15,
  parameter int COLOR_BITS = 16
) (
  lsr_req_if.sink   req,
  input  logic      full,
  output logic      push,
  output lsr_cmd_t  cmd
);

  localparam int CE = COORD_BITS + 1;

  logic signed [CE-1:0]         dx;
  logic signed [CE-1:0]         dy;
  logic                         x_neg;
  logic                         y_neg;
  logic [COORD_BITS-1:0]        adx;
  logic [COORD_BITS-1:0]        ady;
  logic                         flat_h;
  logic                         flat_v;
  logic signed [COORD_BITS-1:0] x_min;
  logic signed [COORD_BITS-1:0] x_max;
  logic signed [COORD_BITS-1:0] y_min;
  logic signed [COORD_BITS-1:0] y_max;

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    dx     = CE'(req.end_x) - CE'(req.start_x);
    dy     = CE'(req.end_y) - CE'(req.start_y);
    x_neg  = dx[CE-1];
    y_neg  = dy[CE-1];
    adx    = x_neg ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady    = y_neg ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    flat_h = (req.start_y == req.end_y);
    flat_v = (req.start_x == req.end_x);
    x_min  = x_neg ? req.end_x : req.start_x;
    x_max  = x_neg ? req.start_x : req.end_x;
    y_min  = y_neg ? req.end_y : req.start_y;
    y_max  = y_neg ? req.start_y : req.end_y;

    cmd.op         = req.cmd;
    cmd.kind       = flat_h ? KIND_HORIZ : (flat_v ? KIND_VERT : KIND_NONE);
    cmd.fixed      = flat_h ? COORD_MAX_BITS'(req.start_y) : COORD_MAX_BITS'(req.start_x);
    cmd.low        = flat_h ? COORD_MAX_BITS'(x_min) : COORD_MAX_BITS'(y_min);
    cmd.high       = flat_h ? COORD_MAX_BITS'(x_max) : COORD_MAX_BITS'(y_max);
    cmd.x0         = COORD_MAX_BITS'(req.start_x);
    cmd.y0         = COORD_MAX_BITS'(req.start_y);
    cmd.x1         = COORD_MAX_BITS'(req.end_x);
    cmd.y1         = COORD_MAX_BITS'(req.end_y);
    cmd.abs_dx     = COORD_MAX_BITS'(adx);
    cmd.abs_dy     = COORD_MAX_BITS'(ady);
    cmd.step_x_neg = x_neg;
    cmd.step_y_neg = y_neg;
    cmd.err0       = ERR_BITS'(signed'({2'b00, adx}) - signed'({2'b00, ady}));
    cmd.color      = COLOR_MAX_BITS'(req.line_color);
  end

endmodule

/* rtl/core/lsr_queue.sv */
// Small FIFO of decoded commands between front and back.
`timescale 1ns / 1ps

module lsr_queue import lsr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lsr_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output lsr_cmd_t pop_cmd
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  lsr_cmd_t              entries [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("command queue count above depth");

endmodule

/* rtl/core/lsr_back.sv */
// Line walker: Bresenham stepping, span coalescing and the output register.
`timescale 1ns / 1ps

module lsr_back import lsr_pkg::*; #(
  parameter int COORD_BITS = 15,
  parameter int COLOR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  lsr_cmd_t   q_cmd,
  output logic       q_pop,
  lsr_span_if.source span
);

  localparam int CE = COORD_BITS + 1;
  localparam int EB = COORD_BITS + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state;
  logic       active;
  logic       walk_done;
  logic [1:0] kind;

  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic [COORD_BITS-1:0]        abs_dx;
  logic [COORD_BITS-1:0]        abs_dy;
  logic                         step_x_neg;
  logic                         step_y_neg;
  logic signed [EB-1:0]         error_term;
  logic signed [COORD_BITS-1:0] span_fixed;
  logic signed [COORD_BITS-1:0] span_low;
  logic signed [COORD_BITS-1:0] span_high;
  logic [COLOR_BITS-1:0]        held_color;

  logic                         out_valid;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic [SPAN_LEN_BITS-1:0]     out_w;
  logic [SPAN_LEN_BITS-1:0]     out_h;
  logic [COLOR_BITS-1:0]        out_color;
  logic                         out_last;

  logic slot_free;
  logic do_load;
  logic do_next;
  logic do_step;
  logic do_final;
  logic do_emit;
  logic at_end;

  // merge of the current pixel
  logic signed [CE-1:0]         px_e;
  logic signed [CE-1:0]         py_e;
  logic signed [CE-1:0]         fx_e;
  logic signed [CE-1:0]         lo_e;
  logic signed [CE-1:0]         hi_e;
  logic                         merged;
  logic                         closed;
  logic [1:0]                   m_kind;
  logic signed [COORD_BITS-1:0] m_fixed;
  logic signed [COORD_BITS-1:0] m_low;
  logic signed [COORD_BITS-1:0] m_high;

  // error-term step
  logic signed [EB:0]           e2;
  logic signed [EB:0]           dx_w;
  logic signed [EB:0]           dy_w;
  logic signed [EB-1:0]         dx_e;
  logic signed [EB-1:0]         dy_e;
  logic                         move_x;
  logic                         move_y;

  // stored span as a rectangle
  logic [CE-1:0]                span_len;
  logic signed [COORD_BITS-1:0] em_x;
  logic signed [COORD_BITS-1:0] em_y;
  logic [SPAN_LEN_BITS-1:0]     em_w;
  logic [SPAN_LEN_BITS-1:0]     em_h;

  assign slot_free = !out_valid || span.ready;
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign do_load   = q_pop && (q_cmd.op == CMD_LOAD);
  assign do_next   = q_pop && (q_cmd.op == CMD_NEXT) && active;
  assign do_step   = (state == ST_WALK) && slot_free;
  assign do_final  = (state == ST_FINAL) && slot_free;
  assign do_emit   = (do_step && closed) || do_final;
  assign at_end    = (cur_x == target_x) && (cur_y == target_y);

  always_comb begin
    px_e    = CE'(cur_x);
    py_e    = CE'(cur_y);
    fx_e    = CE'(span_fixed);
    lo_e    = CE'(span_low);
    hi_e    = CE'(span_high);
    merged  = 1'b0;
    m_kind  = kind;
    m_fixed = span_fixed;
    m_low   = span_low;
    m_high  = span_high;
    unique case (kind)
      KIND_HORIZ: begin
        if (cur_y == span_fixed) begin
          if (px_e == hi_e + CE'(1)) begin
            m_high = cur_x;
            merged = 1'b1;
          end else if (px_e == lo_e - CE'(1)) begin
            m_low  = cur_x;
            merged = 1'b1;
          end
        end
      end
      KIND_VERT: begin
        if (cur_x == span_fixed) begin
          if (py_e == hi_e + CE'(1)) begin
            m_high = cur_y;
            merged = 1'b1;
          end else if (py_e == lo_e - CE'(1)) begin
            m_low  = cur_y;
            merged = 1'b1;
          end
        end
      end
      KIND_POINT: begin
        // a point keeps its row in span_fixed and its column in span_low
        if ((cur_y == span_fixed) &&
            ((px_e == lo_e + CE'(1)) || (px_e == lo_e - CE'(1)))) begin
          m_kind = KIND_HORIZ;
          m_low  = (cur_x < span_low) ? cur_x : span_low;
          m_high = (cur_x > span_low) ? cur_x : span_low;
          merged = 1'b1;
        end else if ((cur_x == span_low) &&
                     ((py_e == fx_e + CE'(1)) || (py_e == fx_e - CE'(1)))) begin
          m_kind  = KIND_VERT;
          m_fixed = cur_x;
          m_low   = (cur_y < span_fixed) ? cur_y : span_fixed;
          m_high  = (cur_y > span_fixed) ? cur_y : span_fixed;
          merged  = 1'b1;
        end
      end
      default: ;
    endcase
    closed = !merged && (kind != KIND_NONE);
    if (!merged) begin
      m_kind  = KIND_POINT;
      m_fixed = cur_y;
      m_low   = cur_x;
      m_high  = cur_x;
    end
  end

  always_comb begin
    e2     = {error_term, 1'b0};
    dx_w   = signed'({3'b000, abs_dx});
    dy_w   = signed'({3'b000, abs_dy});
    dx_e   = signed'({2'b00, abs_dx});
    dy_e   = signed'({2'b00, abs_dy});
    move_x = (e2 > -dy_w);
    move_y = (e2 < dx_w);
  end

  always_comb begin
    span_len = CE'(span_high) - CE'(span_low) + CE'(1);
    if (kind == KIND_VERT) begin
      em_x = span_fixed;
      em_y = span_low;
      em_w = SPAN_LEN_BITS'(1);
      em_h = SPAN_LEN_BITS'(span_len);
    end else begin
      em_x = span_low;
      em_y = span_fixed;
      em_w = SPAN_LEN_BITS'(span_len);
      em_h = SPAN_LEN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      walk_done <= 1'b0;
      kind      <= KIND_NONE;
      out_valid <= 1'b0;
    end else begin
      if (do_emit) begin
        out_valid <= 1'b1;
      end else if (span.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (do_load) begin
            active    <= 1'b1;
            walk_done <= (q_cmd.kind != KIND_NONE);
            kind      <= q_cmd.kind;
          end else if (do_next) begin
            state <= walk_done ? ST_FINAL : ST_WALK;
          end
        end
        ST_WALK: begin
          if (do_step) begin
            kind <= m_kind;
            if (at_end) begin
              walk_done <= 1'b1;
            end
            if (closed) begin
              state <= ST_IDLE;
            end else if (at_end) begin
              state <= ST_FINAL;
            end
          end
        end
        ST_FINAL: begin
          if (do_final) begin
            active    <= 1'b0;
            walk_done <= 1'b0;
            kind      <= KIND_NONE;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      held_color <= q_cmd.color[COLOR_BITS-1:0];
      if (q_cmd.kind != KIND_NONE) begin
        span_fixed <= q_cmd.fixed[COORD_BITS-1:0];
        span_low   <= q_cmd.low[COORD_BITS-1:0];
        span_high  <= q_cmd.high[COORD_BITS-1:0];
      end else begin
        cur_x      <= q_cmd.x0[COORD_BITS-1:0];
        cur_y      <= q_cmd.y0[COORD_BITS-1:0];
        target_x   <= q_cmd.x1[COORD_BITS-1:0];
        target_y   <= q_cmd.y1[COORD_BITS-1:0];
        abs_dx     <= q_cmd.abs_dx[COORD_BITS-1:0];
        abs_dy     <= q_cmd.abs_dy[COORD_BITS-1:0];
        step_x_neg <= q_cmd.step_x_neg;
        step_y_neg <= q_cmd.step_y_neg;
        error_term <= q_cmd.err0[EB-1:0];
      end
    end
    if (do_step) begin
      span_fixed <= m_fixed;
      span_low   <= m_low;
      span_high  <= m_high;
      if (!at_end) begin
        error_term <= error_term - (move_x ? dy_e : {EB{1'b0}})
                                 + (move_y ? dx_e : {EB{1'b0}});
        if (move_x) begin
          cur_x <= cur_x + (step_x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
        end
        if (move_y) begin
          cur_y <= cur_y + (step_y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
        end
      end
    end
    if (do_emit) begin
      out_x     <= em_x;
      out_y     <= em_y;
      out_w     <= em_w;
      out_h     <= em_h;
      out_color <= held_color;
      out_last  <= do_final;
    end
  end

  assign span.valid       = out_valid;
  assign span.span_x      = out_x;
  assign span.span_y      = out_y;
  assign span.span_width  = out_w;
  assign span.span_height = out_h;
  assign span.span_color  = out_color;
  assign span.last_span   = out_last;

  a_walk_state: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (active && !walk_done))
    else $error("walking without an open line");

  a_final_state: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> (active && walk_done))
    else $error("final span without a finished walk");

  a_point_span: assert property (@(posedge clk) disable iff (rst)
    (kind == KIND_POINT) |-> (span_low == span_high))
    else $error("point span with unequal ends");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    ((kind == KIND_HORIZ) || (kind == KIND_VERT)) |-> (span_low <= span_high))
    else $error("run span ends out of order");

  a_emit_kind: assert property (@(posedge clk) disable iff (rst)
    do_emit |-> (kind != KIND_NONE))
    else $error("span emitted with nothing pending");

endmodule
